// ===== rtl/sbo_pkg.sv =====
package sbo_pkg;

  localparam int COLOR_W    = 8;
  localparam int LABEL_IN_W = 16;
  localparam int COORD_W    = 11;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_RED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_GREEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_BLUE  = 3'd4;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;

  // Result queue depth (power of two)
  localparam int FIFO_DEPTH = 4;

  typedef logic [3*COLOR_W-1:0] rgb_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               on_boundary;
    logic               last_of_run;
  } result_t;

endpackage

// ===== rtl/sbo_if.sv =====
interface sbo_pix_in_if import sbo_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [LABEL_IN_W-1:0] label;
  logic [COLOR_W-1:0]    red;
  logic [COLOR_W-1:0]    green;
  logic [COLOR_W-1:0]    blue;

  modport source (output valid, label, red, green, blue, input ready);
  modport sink   (input valid, label, red, green, blue, output ready);
endinterface

interface sbo_pix_out_if import sbo_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] out_red;
  logic [COLOR_W-1:0] out_green;
  logic [COLOR_W-1:0] out_blue;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               on_boundary;
  logic               last_of_run;

  modport source (output valid, out_red, out_green, out_blue, out_row, out_col,
                  on_boundary, last_of_run, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_row, out_col,
                  on_boundary, last_of_run, output ready);
endinterface

// ===== rtl/sbo_ram.sv =====
module sbo_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/superpixel_boundary_overlay.sv =====
// Channel   Dir  Handshake      Beat contents
// in_pix    in   valid/ready    label, red, green, blue (raster order)
// out_pix   out  valid/ready    out_red/green/blue, out_row, out_col, on_boundary,
//                               last_of_run
// cfg_*     in   cfg_we         cfg_index selects register, cfg_wdata is the value
//
// One pixel per clock sustained while out_pix is ready; the last row emits two beats
// per pixel, so there the output port sets the rate (one beat per clock) and input waits.
// A result passes the stage 1 register (the line memory read is registered too), then
// the 4-entry result queue, before it leaves.
// Reset (rst_n low, synchronous) clears counters, the queue and the stage valid;
// the line memory holds no reset and needs no clearing pass.
// in_pix.ready drops only when the result queue could not absorb the worst case.
module superpixel_boundary_overlay import sbo_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int LABEL_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sbo_pix_in_if.sink           in_pix,
  sbo_pix_out_if.source        out_pix,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int LW    = (LABEL_BITS < LABEL_IN_W) ? LABEL_BITS : LABEL_IN_W;
  localparam int RGB_W = 3 * COLOR_W;
  // Line memory word: {label two lines up, label previous line, colour previous line}
  localparam int RAM_W = 2 * LW + RGB_W;
  localparam int FPW   = $clog2(FIFO_DEPTH);
  localparam int FCW   = $clog2(FIFO_DEPTH + 1);

  // Size register is kept as (clamped size - 1), which is what every compare needs
  function automatic int size_m1(input logic [CFG_W-1:0] v, input int maxv);
    int s;
    s = int'(v);
    if (s < 3) begin
      s = 3;
    end else if (s > maxv) begin
      s = maxv;
    end
    return s - 1;
  endfunction

  localparam logic [CW-1:0] WM1_RST = CW'(size_m1(RST_FRAME_WIDTH, MAX_WIDTH));
  localparam logic [RW-1:0] HM1_RST = RW'(size_m1(RST_FRAME_HEIGHT, MAX_HEIGHT));

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [CW-1:0]      wm1_r;
  logic [RW-1:0]      hm1_r;
  logic [COLOR_W-1:0] bnd_red_r, bnd_green_r, bnd_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r       <= WM1_RST;
      hm1_r       <= HM1_RST;
      bnd_red_r   <= '0;
      bnd_green_r <= '0;
      bnd_blue_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:    wm1_r       <= CW'(size_m1(cfg_wdata, MAX_WIDTH));
        CFG_FRAME_HEIGHT:   hm1_r       <= RW'(size_m1(cfg_wdata, MAX_HEIGHT));
        CFG_BOUNDARY_RED:   bnd_red_r   <= cfg_wdata[COLOR_W-1:0];
        CFG_BOUNDARY_GREEN: bnd_green_r <= cfg_wdata[COLOR_W-1:0];
        CFG_BOUNDARY_BLUE:  bnd_blue_r  <= cfg_wdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: accept a pixel, write the line memory, read ahead for the next one.
  // The memory is read every cycle at the column of the next pixel, so at
  // acceptance the read data already holds this column's above/up2/colour; the
  // read issued with the beat (next column) returns the right neighbor in stage 1.
  // ---------------------------------------------------------------------------
  logic             in_acc;
  logic [RW-1:0]    row_r, row_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [LW-1:0]    left_r, left_nxt;
  logic [CW-1:0]    rd_addr;
  logic [RAM_W-1:0] ram_rdata;
  logic [LW-1:0]    lab_in, above_d, up2_d, right_d;
  rgb_t             rgb_in, pcol_d;
  logic             s0_wrap, s0_last, s0_emit, s0_border;

  assign in_acc  = in_pix.valid && in_pix.ready;
  assign lab_in  = in_pix.label[LW-1:0];
  assign rgb_in  = {in_pix.red, in_pix.green, in_pix.blue};

  assign up2_d   = ram_rdata[RAM_W-1 -: LW];
  assign above_d = ram_rdata[RGB_W+LW-1 -: LW];
  assign pcol_d  = ram_rdata[RGB_W-1:0];
  assign right_d = above_d;

  assign s0_wrap   = col_r >= wm1_r;
  assign s0_last   = row_r >= hm1_r;
  assign s0_emit   = row_r != '0;
  // Emitted pixel sits one row up: border when that row is the first or at/after
  // the last, or the column is the first or at/after the last.
  assign s0_border = (row_r == RW'(1)) || (col_r == '0) || (row_r > hm1_r) || s0_wrap;

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    left_nxt = left_r;
    if (in_acc) begin
      if (s0_wrap) begin
        col_nxt  = '0;
        left_nxt = '0;
        row_nxt  = s0_last ? '0 : row_r + RW'(1);
      end else begin
        col_nxt  = col_r + CW'(1);
        left_nxt = above_d;
      end
    end
  end

  assign rd_addr = col_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      left_r <= '0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      left_r <= left_nxt;
    end
  end

  sbo_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (col_r),
    .wdata ({above_d, lab_in, rgb_in}),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: decide paint, build up to two results. Always advances into the
  // result queue (admission in stage 0 guarantees room), so the memory read data
  // seen here is always the right neighbor of this beat.
  // ---------------------------------------------------------------------------
  logic          s1_valid_r;
  logic [RW-1:0] s1_row_r;
  logic [CW-1:0] s1_col_r;
  logic [LW-1:0] s1_above_r, s1_up2_r, s1_left_r, s1_lab_r;
  rgb_t          s1_pcol_r, s1_rgb_r;
  logic          s1_emit_r, s1_last_r, s1_border_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_row_r    <= row_r;
      s1_col_r    <= col_r;
      s1_above_r  <= above_d;
      s1_up2_r    <= up2_d;
      s1_left_r   <= left_r;
      s1_lab_r    <= lab_in;
      s1_pcol_r   <= pcol_d;
      s1_rgb_r    <= rgb_in;
      s1_emit_r   <= s0_emit;
      s1_last_r   <= s0_last;
      s1_border_r <= s0_border;
    end
  end

  logic          paint;
  logic [RW-1:0] s1_er;
  result_t       res_a, res_b, push0;
  logic [1:0]    push_n;

  assign paint = !s1_border_r && ((s1_above_r != right_d) || (s1_above_r != s1_left_r) ||
                                  (s1_above_r != s1_up2_r) || (s1_above_r != s1_lab_r));
  assign s1_er = s1_row_r - RW'(1);

  always_comb begin
    // Pixel one row up
    res_a.red         = paint ? bnd_red_r   : s1_pcol_r[RGB_W-1 -: COLOR_W];
    res_a.green       = paint ? bnd_green_r : s1_pcol_r[2*COLOR_W-1 -: COLOR_W];
    res_a.blue        = paint ? bnd_blue_r  : s1_pcol_r[COLOR_W-1:0];
    res_a.row         = COORD_W'(s1_er);
    res_a.col         = COORD_W'(s1_col_r);
    res_a.on_boundary = paint;
    res_a.last_of_run = !s1_last_r;
    // Last-row pixel itself, always copied
    res_b.red         = s1_rgb_r[RGB_W-1 -: COLOR_W];
    res_b.green       = s1_rgb_r[2*COLOR_W-1 -: COLOR_W];
    res_b.blue        = s1_rgb_r[COLOR_W-1:0];
    res_b.row         = COORD_W'(s1_row_r);
    res_b.col         = COORD_W'(s1_col_r);
    res_b.on_boundary = 1'b0;
    res_b.last_of_run = 1'b1;
    push0             = s1_emit_r ? res_a : res_b;
    push_n            = s1_valid_r ? ({1'b0, s1_emit_r} + {1'b0, s1_last_r}) : 2'd0;
  end

  // ---------------------------------------------------------------------------
  // Result queue: up to two writes and one read per cycle
  // ---------------------------------------------------------------------------
  result_t        fifo_mem_r [FIFO_DEPTH];
  logic [FPW-1:0] wp_r, rp_r, wp1;
  logic [FCW-1:0] cnt_r;
  logic           pop;

  assign wp1 = wp_r + FPW'(1);
  assign pop = out_pix.valid && out_pix.ready;

  always_ff @(posedge clk) begin
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      if ((push_n != 2'd0) && (wp_r == FPW'(i))) begin
        fifo_mem_r[i] <= push0;
      end
      if ((push_n == 2'd2) && (wp1 == FPW'(i))) begin
        fifo_mem_r[i] <= res_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + FPW'(push_n);
      rp_r  <= rp_r + FPW'(pop);
      cnt_r <= cnt_r + FCW'(push_n) - FCW'(pop);
    end
  end

  // Hold input while queue plus in-flight stage 1 could not take two more beats
  assign in_pix.ready = (int'(cnt_r) + int'(push_n) + 2) <= FIFO_DEPTH;

  assign out_pix.valid       = cnt_r != '0;
  assign out_pix.out_red     = fifo_mem_r[rp_r].red;
  assign out_pix.out_green   = fifo_mem_r[rp_r].green;
  assign out_pix.out_blue    = fifo_mem_r[rp_r].blue;
  assign out_pix.out_row     = fifo_mem_r[rp_r].row;
  assign out_pix.out_col     = fifo_mem_r[rp_r].col;
  assign out_pix.on_boundary = fifo_mem_r[rp_r].on_boundary;
  assign out_pix.last_of_run = fifo_mem_r[rp_r].last_of_run;

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= FIFO_DEPTH)
    else $error("result queue overflow");

  a_wrap_col: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s0_wrap) |=> (col_r == '0))
    else $error("column did not wrap at end of line");

  a_last_row_two: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_emit_r && s1_last_r) |-> (push_n == 2'd2))
    else $error("last-row pixel did not push two results");

  a_stage1_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted beat missing from stage 1");
`endif

endmodule
